@@ design/gtr_pkg.sv @@
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, constants and helpers of the glyph text renderer.
// ----------------------------------------------------------------------------
package gtr_pkg;

	localparam int SCREEN_WIDTH  = 240;
	localparam int SCREEN_HEIGHT = 160;
	localparam int GLYPH_COUNT   = 256;

	localparam int GLYPH_W   = $clog2(GLYPH_COUNT);
	localparam int GLYPH_H   = 8;
	localparam int ROW_W     = $clog2(GLYPH_H);
	localparam int FONT_AW   = GLYPH_W + ROW_W;
	localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_H;
	localparam int ADDR_W    = 17;
	localparam int COLOR_W   = 8;
	localparam int ROW_PITCH = SCREEN_WIDTH / 2;
	localparam int WRAP_X    = SCREEN_WIDTH - 8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FORE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd2;

	localparam logic [7:0] CODE_LF = 8'h0A;
	localparam logic [7:0] CODE_CR = 8'h0D;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 48;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_NONE,
		CMD_DRAW
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [GLYPH_W-1:0] glyph;
		logic [ROW_W-1:0]   font_row;
		logic [7:0]         font_bits;
		logic [7:0]         cur_y;
		logic [6:0]         col_half;
		logic [7:0]         row_out;
	} gtr_cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0] fore;
		logic [COLOR_W-1:0] back;
		logic [ADDR_W-1:0]  base;
	} gtr_cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FETCH,
		BK_PRIME,
		BK_EMIT
	} bk_state_t;

	function automatic logic is_white(input logic [7:0] code);
		is_white = code inside {8'h20, [8'h09:8'h0D]};
	endfunction

endpackage

@@ design/gtr_queue.sv @@
// ----------------------------------------------------------------------------
// gtr_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module gtr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gtr_pkg::gtr_cmd_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output gtr_pkg::gtr_cmd_t pop_data
);
	import gtr_pkg::*;

	gtr_cmd_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/gtr_front.sv @@
// ----------------------------------------------------------------------------
// gtr_front
// Accepts items, tracks the cursor and classifies each item into a command.
// ----------------------------------------------------------------------------
module gtr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gtr_pkg::S_TDATA_W-1:0] s_tdata,  // char_code, start_x, start_y,
	                                                 // font_row_index, font_row_bits
	input  logic [gtr_pkg::S_TUSER_W-1:0] s_tuser,  // mode, first_of_string
	output logic                          push,
	output gtr_pkg::gtr_cmd_t             push_data,
	input  logic                          full
);
	import gtr_pkg::*;

	logic [7:0] cx_q, cy_q, ls_q;
	logic       skip_q, done_q;

	logic       mode, first;
	logic [7:0] code, sx, sy, frb;
	logic [2:0] fri;

	logic [7:0] cx, cy, ls;
	logic       skip, done;
	logic [7:0] cx_n, cy_n;
	logic       skip_n, done_n;
	logic [8:0] nx;

	assign mode  = s_tuser[0];
	assign first = s_tuser[1];
	assign code  = s_tdata[7:0];
	assign sx    = s_tdata[15:8];
	assign sy    = s_tdata[23:16];
	assign fri   = s_tdata[26:24];
	assign frb   = s_tdata[34:27];

	assign s_tready = !full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		cx   = first ? sx : cx_q;
		cy   = first ? sy : cy_q;
		ls   = first ? sx : ls_q;
		skip = first ? 1'b0 : skip_q;
		done = first ? 1'b0 : done_q;
		nx   = {1'b0, cx} + 9'd8;

		cx_n   = cx;
		cy_n   = cy;
		skip_n = skip;
		done_n = done;

		push_data           = '0;
		push_data.kind      = CMD_NONE;
		push_data.glyph     = code[GLYPH_W-1:0];
		push_data.font_row  = fri;
		push_data.font_bits = frb;
		push_data.cur_y     = cy;
		push_data.col_half  = cx[7:1];
		push_data.row_out   = cy;

		if (mode) begin
			push_data.kind = CMD_LOAD;
		end else if (done || cy >= 8'(SCREEN_HEIGHT)) begin
			done_n = 1'b1;
		end else if (skip && is_white(code)) begin
			push_data.kind = CMD_NONE;
		end else begin
			skip_n = 1'b0;
			if (code == CODE_LF) begin
				cy_n              = cy + 8'd8;
				cx_n              = ls;
				push_data.row_out = cy_n;
			end else if (code == CODE_CR) begin
				cx_n = ls;
			end else begin
				push_data.kind = CMD_DRAW;
				if (nx >= 9'(WRAP_X)) begin
					skip_n = 1'b1;
					cx_n   = '0;
					cy_n   = cy + 8'd8;
				end else begin
					cx_n = nx[7:0];
				end
				push_data.row_out = cy_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			ls_q   <= '0;
			skip_q <= 1'b0;
			done_q <= 1'b0;
		end else if (push && !mode) begin
			cx_q   <= cx_n;
			cy_q   <= cy_n;
			ls_q   <= ls;
			skip_q <= skip_n;
			done_q <= done_n;
		end
	end

endmodule

@@ design/gtr_back.sv @@
// ----------------------------------------------------------------------------
// gtr_back
// Holds the font store and turns commands into framebuffer write items.
// ----------------------------------------------------------------------------
module gtr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gtr_pkg::gtr_cfg_t             cfg,
	input  logic                          q_valid,
	input  gtr_pkg::gtr_cmd_t             q_data,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gtr_pkg::M_TDATA_W-1:0] m_tdata,  // word_addr, pixel_pair, cursor_row
	output logic                          m_tuser,  // write_enable
	output logic                          m_tlast
);
	import gtr_pkg::*;

	logic [7:0] font_mem [FONT_DEPTH];
	logic [7:0] rd_q;
	logic [7:0] bits_q;

	bk_state_t          state_q, state_n;
	logic [GLYPH_W-1:0] glyph_q;
	logic [ROW_W-1:0]   row_q;
	logic [1:0]         k_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [7:0]         crow_q;

	logic               out_valid_q;
	logic               out_we_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [15:0]        out_pix_q;
	logic [7:0]         out_row_q;
	logic               out_last_q;

	logic               can_load;
	logic               out_ld;
	logic               ld_we, ld_last;
	logic [ADDR_W-1:0]  ld_addr;
	logic [15:0]        ld_pix;
	logic [7:0]         ld_row;
	logic               mem_we;
	logic [FONT_AW-1:0] rd_addr;
	logic [FONT_AW-1:0] wr_addr;
	logic [15:0]        y_off;
	logic [ADDR_W-1:0]  start_addr;
	logic               row_end;

	assign can_load   = !out_valid_q || m_tready;
	assign y_off      = 16'(q_data.cur_y) * 16'(ROW_PITCH);
	assign start_addr = cfg.base + ADDR_W'(y_off) + ADDR_W'(q_data.col_half);
	assign wr_addr    = {q_data.glyph, q_data.font_row};
	assign row_end    = (k_q == 2'd3);

	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop && q_data.kind == CMD_DRAW) begin
					state_n = BK_FETCH;
				end
			end
			BK_FETCH: state_n = BK_PRIME;
			BK_PRIME: state_n = BK_EMIT;
			BK_EMIT: begin
				if (can_load && row_end && row_q == ROW_W'(GLYPH_H - 1)) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		out_ld  = 1'b0;
		mem_we  = 1'b0;
		ld_we   = 1'b0;
		ld_addr = '0;
		ld_pix  = '0;
		ld_row  = crow_q;
		ld_last = 1'b0;
		rd_addr = {glyph_q, row_q + 1'b1};
		case (state_q)
			BK_IDLE: begin
				pop = q_valid && can_load;
				if (pop) begin
					case (q_data.kind)
						CMD_LOAD: mem_we = 1'b1;
						CMD_NONE: begin
							out_ld  = 1'b1;
							ld_row  = q_data.row_out;
							ld_last = 1'b1;
						end
						default: ;
					endcase
				end
			end
			BK_FETCH: rd_addr = {glyph_q, ROW_W'(0)};
			BK_EMIT: begin
				out_ld  = can_load;
				ld_we   = 1'b1;
				ld_addr = addr_q + ADDR_W'(k_q);
				ld_pix  = {bits_q[{~k_q, 1'b0}] ? cfg.fore : cfg.back,
				           bits_q[{~k_q, 1'b1}] ? cfg.fore : cfg.back};
				ld_last = row_end && row_q == ROW_W'(GLYPH_H - 1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			font_mem[wr_addr] <= q_data.font_bits;
		end
		rd_q <= font_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop && q_data.kind == CMD_DRAW) begin
			glyph_q <= q_data.glyph;
			addr_q  <= start_addr;
			crow_q  <= q_data.row_out;
		end else if (state_q == BK_EMIT && can_load && row_end) begin
			addr_q <= addr_q + ADDR_W'(ROW_PITCH);
		end
		if (state_q == BK_PRIME || (state_q == BK_EMIT && can_load && row_end)) begin
			bits_q <= rd_q;
		end
		if (out_ld) begin
			out_we_q   <= ld_we;
			out_addr_q <= ld_addr;
			out_pix_q  <= ld_pix;
			out_row_q  <= ld_row;
			out_last_q <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			row_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (pop) begin
				row_q <= '0;
				k_q   <= '0;
			end else if (state_q == BK_EMIT && can_load) begin
				k_q <= k_q + 1'b1;
				if (row_end) begin
					row_q <= row_q + 1'b1;
				end
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_we_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'b0, out_row_q, out_pix_q, out_addr_q};

	a_last_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tuser |-> state_q == BK_IDLE)
		else $error("final glyph write shown while sequencer busy");

	a_nowrite_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result without write is not final");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_EMIT && !can_load |=> $stable(k_q) && $stable(row_q))
		else $error("pair counter moved while output stalled");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == BK_IDLE && q_valid)
		else $error("command taken while sequencer busy");

endmodule

@@ design/glyph_text_renderer_top.sv @@
// ----------------------------------------------------------------------------
// glyph_text_renderer_top
// 8x8 bitmap font text renderer with configuration registers.
// ----------------------------------------------------------------------------
// A glyph gives 32 write items, one per cycle while the output is not stalled,
// after the command pop and the font store prefetch in the FETCH and PRIME
// states of the back sequencer. Font loads give no item, and control or
// dropped characters give one item each.
// Reset clears the cursor, the queue and the output, and restores the color
// and base registers; the font store keeps its contents.
module glyph_text_renderer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gtr_pkg::S_TDATA_W-1:0] s_tdata,  // char_code, start_x, start_y,
	                                                 // font_row_index, font_row_bits
	input  logic [gtr_pkg::S_TUSER_W-1:0] s_tuser,  // mode, first_of_string
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gtr_pkg::M_TDATA_W-1:0] m_tdata,  // word_addr, pixel_pair, cursor_row
	output logic                          m_tuser,  // write_enable
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gtr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gtr_pkg::ADDR_W-1:0]    cfg_data
);
	import gtr_pkg::*;

	gtr_cfg_t cfg_q;
	gtr_cmd_t push_data, pop_data;
	logic     push, full, pop, q_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fore <= '1;
			cfg_q.back <= '0;
			cfg_q.base <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FORE: cfg_q.fore <= cfg_data[COLOR_W-1:0];
				CFG_BACK: cfg_q.back <= cfg_data[COLOR_W-1:0];
				CFG_BASE: cfg_q.base <= cfg_data;
				default:  ;
			endcase
		end
	end

	gtr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	gtr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_data  (pop_data)
	);

	gtr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
